FILE: rtl/core/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package jsu_pkg;

   // Kind of one result.
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Error codes reported with an error result.
   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_NO_QUOTE     = 4'd1,
      ERR_ESC_END      = 4'd2,
      ERR_BAD_ESC      = 4'd3,
      ERR_BAD_HEX      = 4'd4,
      ERR_NO_LOW       = 4'd5,
      ERR_BAD_LOW      = 4'd6,
      ERR_LONE_LOW     = 4'd7,
      ERR_UNTERMINATED = 4'd8
   } err_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
   localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [20:0] UTF8_MAX_1    = 21'h00007F;
   localparam logic [20:0] UTF8_MAX_2    = 21'h0007FF;
   localparam logic [20:0] UTF8_MAX_3    = 21'h00FFFF;

   // Result group that one request produces: up to four results.
   typedef struct packed {
      logic            any;
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      kind_type        kind;
      err_type         err;
   } group_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } utf8_type;

   function automatic hex_type nibble_of(input logic [7:0] b);
      hex_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.val = 4'(b - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic utf8_type encode_utf8(input logic [20:0] cp);
      utf8_type r;
      r.bytes    = '0;
      r.last_idx = 2'd0;
      if (cp <= UTF8_MAX_1) begin
         r.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp <= UTF8_MAX_2) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.last_idx = 2'd1;
      end else if (cp <= UTF8_MAX_3) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.last_idx = 2'd2;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.last_idx = 2'd3;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/jsu_req_if.sv
// Request channel of the JSON string unescaper: one raw byte or end of text.
// Depends on nothing.
`timescale 1ns / 1ps

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

FILE: rtl/core/jsu_rsp_if.sv
// Result channel of the JSON string unescaper: one decoded byte or status.
// Depends on nothing.
`timescale 1ns / 1ps

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic [3:0] error_code;
   logic       last_of_run;

   modport source (output valid, output out_byte, output kind, output error_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input kind, input error_code,
                   input last_of_run, output ready);
endinterface

FILE: rtl/core/jsu_decode.sv
// Parser state registers and the single-pass decode of one request.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               end_of_text,
   output jsu_pkg::group_type grp
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_STR     = 4'd1,
      PH_ESC     = 4'd2,
      PH_HEX1    = 4'd3,
      PH_WANT_BS = 4'd4,
      PH_WANT_U  = 4'd5,
      PH_HEX2    = 4'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] accum_ff, accum_in;
   logic [9:0]  high_ff, high_in;
   logic [1:0]  count_ff, count_in;

   jsu_pkg::hex_type  hexd;
   jsu_pkg::utf8_type enc;
   logic [15:0]       accum_next;
   logic [20:0]       pair_cp;
   logic [20:0]       emit_cp;
   logic              emit_req;
   logic              fail_req;
   jsu_pkg::err_type  fail_code;
   logic              is_high;
   logic              is_low;

   assign hexd       = jsu_pkg::nibble_of(data_byte);
   assign accum_next = {accum_ff[11:0], hexd.val};
   assign pair_cp    = jsu_pkg::SUPP_BASE + {1'b0, high_ff, accum_next[9:0]};
   assign is_high    = accum_next >= jsu_pkg::SURR_HIGH_MIN &&
                       accum_next <= jsu_pkg::SURR_HIGH_MAX;
   assign is_low     = accum_next >= jsu_pkg::SURR_LOW_MIN &&
                       accum_next <= jsu_pkg::SURR_LOW_MAX;
   assign enc        = jsu_pkg::encode_utf8(emit_cp);

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      high_in   = high_ff;
      count_in  = count_ff;
      emit_req  = 1'b0;
      emit_cp   = {5'd0, accum_next};
      fail_req  = 1'b0;
      fail_code = jsu_pkg::ERR_NONE;
      grp.any      = 1'b0;
      grp.bytes    = '0;
      grp.last_idx = 2'd0;
      grp.kind     = jsu_pkg::KIND_BYTE;
      grp.err      = jsu_pkg::ERR_NONE;

      unique case (phase_ff)
         PH_STR: begin
            if (end_of_text) begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_UNTERMINATED;
            end else if (data_byte == jsu_pkg::CH_QUOTE) begin
               grp.any  = 1'b1;
               grp.kind = jsu_pkg::KIND_DONE;
               phase_in = PH_IDLE;
            end else if (data_byte == jsu_pkg::CH_BACKSLASH) begin
               phase_in = PH_ESC;
            end else begin
               grp.any      = 1'b1;
               grp.bytes[0] = data_byte;
            end
         end
         PH_ESC: begin
            if (end_of_text) begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_ESC_END;
            end else begin
               phase_in = PH_STR;
               grp.any  = 1'b1;
               unique case (data_byte)
                  jsu_pkg::CH_QUOTE,
                  jsu_pkg::CH_BACKSLASH,
                  jsu_pkg::CH_SLASH:     grp.bytes[0] = data_byte;
                  jsu_pkg::CH_LOWER_B:   grp.bytes[0] = 8'h08;
                  jsu_pkg::CH_LOWER_F:   grp.bytes[0] = 8'h0C;
                  jsu_pkg::CH_LOWER_N:   grp.bytes[0] = 8'h0A;
                  jsu_pkg::CH_LOWER_R:   grp.bytes[0] = 8'h0D;
                  jsu_pkg::CH_LOWER_T:   grp.bytes[0] = 8'h09;
                  jsu_pkg::CH_LOWER_U: begin
                     grp.any  = 1'b0;
                     phase_in = PH_HEX1;
                     accum_in = '0;
                     count_in = '0;
                  end
                  default: begin
                     fail_req  = 1'b1;
                     fail_code = jsu_pkg::ERR_BAD_ESC;
                  end
               endcase
            end
         end
         PH_HEX1, PH_HEX2: begin
            if (end_of_text) begin
               fail_req  = 1'b1;
               fail_code = (phase_ff == PH_HEX1) ? jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_NO_LOW;
            end else if (!hexd.ok) begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_BAD_HEX;
            end else if (count_ff != 2'd3) begin
               accum_in = accum_next;
               count_in = count_ff + 2'd1;
            end else begin
               accum_in = '0;
               count_in = '0;
               if (phase_ff == PH_HEX1) begin
                  if (is_high) begin
                     high_in  = accum_next[9:0];
                     phase_in = PH_WANT_BS;
                  end else if (is_low) begin
                     fail_req  = 1'b1;
                     fail_code = jsu_pkg::ERR_LONE_LOW;
                  end else begin
                     emit_req = 1'b1;
                     phase_in = PH_STR;
                  end
               end else begin
                  if (is_low) begin
                     emit_req = 1'b1;
                     emit_cp  = pair_cp;
                     phase_in = PH_STR;
                  end else begin
                     fail_req  = 1'b1;
                     fail_code = jsu_pkg::ERR_BAD_LOW;
                  end
               end
            end
         end
         PH_WANT_BS: begin
            if (!end_of_text && data_byte == jsu_pkg::CH_BACKSLASH) begin
               phase_in = PH_WANT_U;
            end else begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_NO_LOW;
            end
         end
         PH_WANT_U: begin
            if (!end_of_text && data_byte == jsu_pkg::CH_LOWER_U) begin
               phase_in = PH_HEX2;
               accum_in = '0;
               count_in = '0;
            end else begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_NO_LOW;
            end
         end
         default: begin
            // Idle, and any phase code without a meaning.
            phase_in = PH_IDLE;
            if (end_of_text) begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_NO_QUOTE;
            end else if (data_byte == jsu_pkg::CH_SPACE ||
                         (data_byte >= jsu_pkg::CH_TAB && data_byte <= jsu_pkg::CH_CR)) begin
               phase_in = PH_IDLE;
            end else if (data_byte == jsu_pkg::CH_QUOTE) begin
               phase_in = PH_STR;
            end else begin
               fail_req  = 1'b1;
               fail_code = jsu_pkg::ERR_NO_QUOTE;
            end
         end
      endcase

      if (emit_req) begin
         grp.any      = 1'b1;
         grp.bytes    = enc.bytes;
         grp.last_idx = enc.last_idx;
      end

      // Every failure reports once and drops back to idle with cleared state.
      if (fail_req) begin
         grp.any      = 1'b1;
         grp.bytes    = '0;
         grp.last_idx = 2'd0;
         grp.kind     = jsu_pkg::KIND_ERROR;
         grp.err      = fail_code;
         phase_in     = PH_IDLE;
         accum_in     = '0;
         high_in      = '0;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= '0;
         high_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         high_ff  <= high_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/jsu_serial.sv
// Result register that holds one request's result group and hands it out
// one result per cycle while the receiver is ready. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_serial (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_pkg::group_type grp,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         out_byte,
   output logic [1:0]         kind,
   output logic [3:0]         error_code,
   output logic               last_of_run
);

   logic               valid_ff, valid_in;
   jsu_pkg::group_type grp_ff, grp_in;
   logic [1:0]         idx_ff, idx_in;
   logic               at_last;
   logic               pop;

   assign at_last = idx_ff == grp_ff.last_idx;
   assign pop     = valid_ff && rsp_ready;
   assign free    = !valid_ff || (pop && at_last);

   always_comb begin
      valid_in = valid_ff;
      grp_in   = grp_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         grp_in   = grp;
         idx_in   = 2'd0;
      end else if (pop) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      grp_ff <= grp_in;
      idx_ff <= idx_in;
   end

   assign rsp_valid   = valid_ff;
   assign out_byte    = grp_ff.bytes[idx_ff];
   assign kind        = grp_ff.kind;
   assign error_code  = grp_ff.err;
   assign last_of_run = at_last;

endmodule

FILE: rtl/core/json_string_unescape_core.sv
// Top level of the JSON string unescaper: request and result channels.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_decode and jsu_serial.
`timescale 1ns / 1ps

// The block takes the raw bytes of one JSON string token, one byte per
// request, and returns the decoded bytes as UTF-8, followed by a completion
// result at the closing quote or an error result with its code. A request
// is decoded in the cycle it is accepted and its results appear on the
// result channel from the next cycle on. While the receiver is ready, a
// stream of plain text flows at one byte per cycle. A request that yields
// more than one result (a unicode escape gives up to four UTF-8 bytes)
// holds the result register until each is taken, and the next request is
// accepted in the cycle in which the last of them is taken. That single
// result register, which the decoded group of a request waits in, is what
// sets the rate. The last result of each request carries last_of_run.

module json_string_unescape_core (
   input logic         clock,
   input logic         reset,
   jsu_req_if.sink     req_chan,
   jsu_rsp_if.source   rsp_chan
);

   jsu_pkg::group_type grp;
   logic               free;
   logic               accept;

   // A request is taken whenever the result register is empty or hands out
   // its final result in this same cycle.
   assign req_chan.ready = free;
   assign accept         = req_chan.valid && free;

   // Parser state and the combinational decode of the current request.
   jsu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_chan.data_byte),
      .end_of_text (req_chan.end_of_text),
      .grp         (grp)
   );

   // Requests that produce no result (whitespace, backslash, most hex digits)
   // leave the result register alone.
   jsu_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && grp.any),
      .grp         (grp),
      .free        (free),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .out_byte    (rsp_chan.out_byte),
      .kind        (rsp_chan.kind),
      .error_code  (rsp_chan.error_code),
      .last_of_run (rsp_chan.last_of_run)
   );

endmodule

FILE: rtl/core/jsu_checker.sv
// Port-level checks of the JSON string unescaper, bound to its top level.
// Depends on jsu_pkg and json_string_unescape_core.
`timescale 1ns / 1ps

module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic [1:0] kind,
   input logic [3:0] error_code,
   input logic       last_of_run
);

   // An error ends the run of its request and carries a real code.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == jsu_pkg::KIND_ERROR |->
         error_code != jsu_pkg::ERR_NONE && out_byte == 8'd0 && last_of_run)
      else $error("error result malformed");

   // Anything other than an error is a byte or a completion with no code.
   a_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != jsu_pkg::KIND_ERROR |->
         (kind == jsu_pkg::KIND_BYTE || kind == jsu_pkg::KIND_DONE) &&
         error_code == jsu_pkg::ERR_NONE)
      else $error("non-error result with bad kind or code");

   // Completion stands alone as the only result of the closing quote.
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == jsu_pkg::KIND_DONE |-> out_byte == 8'd0 && last_of_run)
      else $error("completion result malformed");

   // While a result is stalled, no new request may enter.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while result stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(out_byte) && $stable(kind) &&
         $stable(error_code) && $stable(last_of_run))
      else $error("stalled result changed");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .kind        (rsp_chan.kind),
   .error_code  (rsp_chan.error_code),
   .last_of_run (rsp_chan.last_of_run)
);

FILE: verif/tb_json_string_unescape_core.sv
// Self-checking testbench for json_string_unescape_core: directed and random raw JSON
// string bytes go in, and the decoded result stream is checked against an in-bench decoder.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_json_string_unescape_core;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 78;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 16;

   // Decoder position inside a string token.
   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_STR,
      SCAN_ESC,
      SCAN_HEX1,
      SCAN_WANT_BS,
      SCAN_WANT_U,
      SCAN_HEX2
   } scan_phase_type;

   // One raw input request.
   typedef struct packed {
      logic [7:0] data;
      logic       eot;
   } raw_item_type;

   // One decoded result as it should appear on the result channel.
   typedef struct packed {
      logic [7:0]        byte_val;
      jsu_pkg::kind_type kind;
      jsu_pkg::err_type  err;
      logic              last;
   } decoded_type;

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_bus ();
   jsu_rsp_if rsp_bus ();

   json_string_unescape_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #4 clock = ~clock;

   // Raw bytes waiting to be offered, and decoded results still owed by the block.
   raw_item_type raw_bytes_to_send[$];
   decoded_type  expected_decoded[$];
   decoded_type  request_results[$];

   // Decoder state that mirrors the block.
   scan_phase_type scan_phase   = SCAN_IDLE;
   logic [15:0]    hex_acc      = '0;
   logic [9:0]     high_bits    = '0;
   logic [1:0]     digits_taken = '0;

   // Traffic shaping, in percent, and the long receiver hold-off.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holds_asked   = 0;
   int holds_started = 0;
   int hold_left     = 0;

   int          cycle_count     = 0;
   int          mismatch_count  = 0;
   int          counted_items   = 0;
   int          requests_taken  = 0;
   int          bytes_checked   = 0;
   int          strings_done    = 0;
   int          errors_checked  = 0;
   logic [8:0]  err_codes_seen  = '0;

   // ------------------------------------------------------------------
   // Decoder used for prediction
   // ------------------------------------------------------------------

   function automatic int hex_nibble(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
      return -1;
   endfunction

   function automatic void add_result(logic [7:0] b, jsu_pkg::kind_type k,
                                      jsu_pkg::err_type e);
      decoded_type r;
      r = '{byte_val: b, kind: k, err: e, last: 1'b0};
      request_results = {request_results, r};
   endfunction

   function automatic void add_byte(logic [7:0] b);
      add_result(b, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
   endfunction

   // An error sends the decoder back to idle and clears the escape state.
   function automatic void add_failure(jsu_pkg::err_type e);
      add_result(8'h00, jsu_pkg::KIND_ERROR, e);
      scan_phase   = SCAN_IDLE;
      hex_acc      = '0;
      high_bits    = '0;
      digits_taken = '0;
   endfunction

   function automatic void add_code_point(logic [20:0] cp);
      if (cp <= 21'h7F) begin
         add_byte(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         add_byte(8'hC0 | 8'(cp >> 6));
         add_byte(8'h80 | 8'(cp & 21'h3F));
      end else if (cp <= 21'hFFFF) begin
         add_byte(8'hE0 | 8'(cp >> 12));
         add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         add_byte(8'h80 | 8'(cp & 21'h3F));
      end else begin
         add_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
         add_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
         add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         add_byte(8'h80 | 8'(cp & 21'h3F));
      end
   endfunction

   // Runs one accepted request through the decoder and queues what it yields.
   function automatic void decode_raw_item(raw_item_type it);
      int nib;
      request_results.delete();
      case (scan_phase)
         SCAN_STR: begin
            if (it.eot) begin
               add_failure(jsu_pkg::ERR_UNTERMINATED);
            end else if (it.data == jsu_pkg::CH_QUOTE) begin
               add_result(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
               scan_phase = SCAN_IDLE;
            end else if (it.data == jsu_pkg::CH_BACKSLASH) begin
               scan_phase = SCAN_ESC;
            end else begin
               add_byte(it.data);
            end
         end
         SCAN_ESC: begin
            if (it.eot) begin
               add_failure(jsu_pkg::ERR_ESC_END);
            end else begin
               scan_phase = SCAN_STR;
               case (it.data)
                  jsu_pkg::CH_QUOTE,
                  jsu_pkg::CH_BACKSLASH,
                  jsu_pkg::CH_SLASH:   add_byte(it.data);
                  jsu_pkg::CH_LOWER_B: add_byte(8'h08);
                  jsu_pkg::CH_LOWER_F: add_byte(8'h0C);
                  jsu_pkg::CH_LOWER_N: add_byte(8'h0A);
                  jsu_pkg::CH_LOWER_R: add_byte(8'h0D);
                  jsu_pkg::CH_LOWER_T: add_byte(8'h09);
                  jsu_pkg::CH_LOWER_U: begin
                     scan_phase   = SCAN_HEX1;
                     hex_acc      = '0;
                     digits_taken = '0;
                  end
                  default: add_failure(jsu_pkg::ERR_BAD_ESC);
               endcase
            end
         end
         SCAN_HEX1, SCAN_HEX2: begin
            nib = it.eot ? -1 : hex_nibble(it.data);
            if (it.eot) begin
               add_failure(scan_phase == SCAN_HEX1 ? jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_NO_LOW);
            end else if (nib < 0) begin
               add_failure(jsu_pkg::ERR_BAD_HEX);
            end else begin
               hex_acc = {hex_acc[11:0], 4'(nib)};
               if (digits_taken != 2'd3) begin
                  digits_taken = digits_taken + 2'd1;
               end else begin
                  digits_taken = '0;
                  if (scan_phase == SCAN_HEX1) begin
                     if (hex_acc >= jsu_pkg::SURR_HIGH_MIN &&
                         hex_acc <= jsu_pkg::SURR_HIGH_MAX) begin
                        high_bits  = 10'(hex_acc - jsu_pkg::SURR_HIGH_MIN);
                        scan_phase = SCAN_WANT_BS;
                     end else if (hex_acc >= jsu_pkg::SURR_LOW_MIN &&
                                  hex_acc <= jsu_pkg::SURR_LOW_MAX) begin
                        add_failure(jsu_pkg::ERR_LONE_LOW);
                     end else begin
                        add_code_point({5'd0, hex_acc});
                        scan_phase = SCAN_STR;
                     end
                  end else if (hex_acc >= jsu_pkg::SURR_LOW_MIN &&
                               hex_acc <= jsu_pkg::SURR_LOW_MAX) begin
                     // Join the pair: ten bits from each half above the base.
                     add_code_point(jsu_pkg::SUPP_BASE + {1'b0, high_bits, hex_acc[9:0]});
                     scan_phase = SCAN_STR;
                  end else begin
                     add_failure(jsu_pkg::ERR_BAD_LOW);
                  end
                  hex_acc = '0;
               end
            end
         end
         SCAN_WANT_BS: begin
            if (!it.eot && it.data == jsu_pkg::CH_BACKSLASH) scan_phase = SCAN_WANT_U;
            else add_failure(jsu_pkg::ERR_NO_LOW);
         end
         SCAN_WANT_U: begin
            if (!it.eot && it.data == jsu_pkg::CH_LOWER_U) begin
               scan_phase   = SCAN_HEX2;
               hex_acc      = '0;
               digits_taken = '0;
            end else begin
               add_failure(jsu_pkg::ERR_NO_LOW);
            end
         end
         default: begin
            scan_phase = SCAN_IDLE;
            if (it.eot) begin
               add_failure(jsu_pkg::ERR_NO_QUOTE);
            end else if (it.data == jsu_pkg::CH_SPACE ||
                         (it.data >= jsu_pkg::CH_TAB && it.data <= jsu_pkg::CH_CR)) begin
               // Whitespace ahead of a token is dropped silently.
            end else if (it.data == jsu_pkg::CH_QUOTE) begin
               scan_phase = SCAN_STR;
            end else begin
               add_failure(jsu_pkg::ERR_NO_QUOTE);
            end
         end
      endcase
      if (request_results.size() != 0) request_results[$].last = 1'b1;
      expected_decoded = {expected_decoded, request_results};
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   function automatic void queue_raw(logic [7:0] b, logic eot, bit counted);
      raw_item_type it;
      it = '{data: b, eot: eot};
      raw_bytes_to_send = {raw_bytes_to_send, it};
      if (counted) counted_items++;
   endfunction

   function automatic void queue_byte(logic [7:0] b);
      queue_raw(b, 1'b0, 1'b1);
   endfunction

   // The data lanes carry noise on end of text; the block must ignore them.
   function automatic void queue_end();
      queue_raw(8'($urandom), 1'b1, 1'b1);
   endfunction

   function automatic void queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   // Queues the first n hex digits of v, most significant first.
   function automatic void queue_hex(logic [15:0] v, int n);
      for (int i = 0; i < n; i++) queue_byte(hex_char(v[15 - 4 * i -: 4]));
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (hex_nibble(b) >= 0);
      return b;
   endfunction

   function automatic void queue_escape_u(logic [15:0] v);
      queue_byte(jsu_pkg::CH_BACKSLASH);
      queue_byte(jsu_pkg::CH_LOWER_U);
      queue_hex(v, 4);
   endfunction

   function automatic logic [15:0] lead_half_code();
      case ($urandom_range(7))
         0:       return jsu_pkg::SURR_HIGH_MIN;
         1:       return jsu_pkg::SURR_HIGH_MAX;
         default: return 16'($urandom_range(jsu_pkg::SURR_HIGH_MIN, jsu_pkg::SURR_HIGH_MAX));
      endcase
   endfunction

   function automatic logic [15:0] trail_half_code();
      case ($urandom_range(7))
         0:       return jsu_pkg::SURR_LOW_MIN;
         1:       return jsu_pkg::SURR_LOW_MAX;
         default: return 16'($urandom_range(jsu_pkg::SURR_LOW_MIN, jsu_pkg::SURR_LOW_MAX));
      endcase
   endfunction

   // A code point in the basic plane outside the surrogate range, spread over
   // the one, two and three byte encodings with their boundaries favored.
   function automatic logic [15:0] plain_code_point();
      logic [15:0] v;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(5))
               0:       v = 16'h0000;
               1:       v = 16'h007F;
               2:       v = 16'h0080;
               3:       v = 16'h07FF;
               4:       v = 16'h0800;
               default: v = 16'hFFFF;
            endcase
         end
         1, 2:    v = 16'($urandom_range('h7F));
         3, 4:    v = 16'($urandom_range('h80, 'h7FF));
         default: do v = 16'($urandom_range('h800, 'hFFFF));
                  while (v >= jsu_pkg::SURR_HIGH_MIN && v <= jsu_pkg::SURR_LOW_MAX);
      endcase
      return v;
   endfunction

   function automatic logic [7:0] simple_escape_letter();
      case ($urandom_range(7))
         0:       return jsu_pkg::CH_QUOTE;
         1:       return jsu_pkg::CH_BACKSLASH;
         2:       return jsu_pkg::CH_SLASH;
         3:       return jsu_pkg::CH_LOWER_B;
         4:       return jsu_pkg::CH_LOWER_F;
         5:       return jsu_pkg::CH_LOWER_N;
         6:       return jsu_pkg::CH_LOWER_R;
         default: return jsu_pkg::CH_LOWER_T;
      endcase
   endfunction

   // A malformed tail inside an open string; each leaves the block idle.
   function automatic void queue_broken_tail();
      logic [7:0]  b;
      logic [15:0] v;
      int          k;
      k = $urandom_range(3);
      v = 16'($urandom);
      case ($urandom_range(9))
         0: begin
            queue_byte(jsu_pkg::CH_BACKSLASH);
            queue_end();
         end
         1: begin
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH ||
                   b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_LOWER_B ||
                   b == jsu_pkg::CH_LOWER_F || b == jsu_pkg::CH_LOWER_N ||
                   b == jsu_pkg::CH_LOWER_R || b == jsu_pkg::CH_LOWER_T ||
                   b == jsu_pkg::CH_LOWER_U);
            queue_byte(jsu_pkg::CH_BACKSLASH);
            queue_byte(b);
         end
         2, 3: begin
            queue_byte(jsu_pkg::CH_BACKSLASH);
            queue_byte(jsu_pkg::CH_LOWER_U);
            queue_hex(v, k);
            if ($urandom_range(1)) queue_byte(non_hex_byte());
            else queue_end();
         end
         4: begin
            queue_escape_u(lead_half_code());
            if ($urandom_range(3) == 0) begin
               queue_end();
            end else begin
               do b = 8'($urandom); while (b == jsu_pkg::CH_BACKSLASH);
               queue_byte(b);
            end
         end
         5: begin
            queue_escape_u(lead_half_code());
            queue_byte(jsu_pkg::CH_BACKSLASH);
            if ($urandom_range(3) == 0) begin
               queue_end();
            end else begin
               do b = 8'($urandom); while (b == jsu_pkg::CH_LOWER_U);
               queue_byte(b);
            end
         end
         6: begin
            // End of text somewhere inside the second escape of a pair.
            queue_escape_u(lead_half_code());
            queue_byte(jsu_pkg::CH_BACKSLASH);
            queue_byte(jsu_pkg::CH_LOWER_U);
            queue_hex(v, k);
            queue_end();
         end
         7: begin
            queue_escape_u(lead_half_code());
            queue_byte(jsu_pkg::CH_BACKSLASH);
            queue_byte(jsu_pkg::CH_LOWER_U);
            queue_hex(v, k);
            queue_byte(non_hex_byte());
         end
         8: begin
            queue_escape_u(lead_half_code());
            do v = 16'($urandom);
            while (v >= jsu_pkg::SURR_LOW_MIN && v <= jsu_pkg::SURR_LOW_MAX);
            queue_escape_u(v);
         end
         default: queue_escape_u(trail_half_code());
      endcase
   endfunction

   // One token: optional leading whitespace, then mostly a well-formed string
   // with random content, sometimes a missing quote, a cut-off text or a bad tail.
   function automatic void queue_token();
      logic [7:0] b;
      int         r;
      repeat ($urandom_range(2)) begin
         if ($urandom_range(2) == 0)
            queue_raw($urandom_range(5) == 5 ? jsu_pkg::CH_SPACE :
                      jsu_pkg::CH_TAB + 8'($urandom_range(4)), 1'b0, 1'b0);
      end
      if ($urandom_range(15) == 0) begin
         if ($urandom_range(3) == 0) begin
            queue_end();
         end else begin
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_SPACE ||
                   (b >= jsu_pkg::CH_TAB && b <= jsu_pkg::CH_CR));
            queue_byte(b);
         end
         return;
      end
      queue_byte(jsu_pkg::CH_QUOTE);
      repeat ($urandom_range(8)) begin
         r = $urandom_range(99);
         if (r < 45) begin
            do b = 8'($urandom); while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH);
            queue_byte(b);
         end else if (r < 60) begin
            queue_byte(jsu_pkg::CH_BACKSLASH);
            queue_byte(simple_escape_letter());
         end else if (r < 75) begin
            queue_escape_u(plain_code_point());
         end else if (r < 88) begin
            queue_escape_u(lead_half_code());
            queue_escape_u(trail_half_code());
         end else begin
            queue_broken_tail();
            return;
         end
      end
      if ($urandom_range(19) == 0) queue_end();
      else queue_byte(jsu_pkg::CH_QUOTE);
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers the next queued byte, holding it until taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      raw_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (raw_bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = raw_bytes_to_send.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.data_byte   <= nxt.data;
            req_bus.end_of_text <= nxt.eot;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, started on request from the stimulus sequence.
   always @(posedge clock) begin
      if (holds_started != holds_asked) begin
         hold_left     <= HOLD_CYCLES;
         holds_started <= holds_started + 1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result receiver: random stalls plus the long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor. Results are checked before the request of the same edge is
   // predicted, so a stray result can never match a fresh expectation.
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      decoded_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_decoded.size() == 0) begin
               $display("%0t: unexpected result, expected none, got byte %0h kind %0d err %0d",
                        $time, rsp_bus.out_byte, rsp_bus.kind, rsp_bus.error_code);
               mismatch_count++;
            end else begin
               want = expected_decoded.pop_front();
               check_field("out_byte", want.byte_val, rsp_bus.out_byte);
               check_field("kind", 8'(want.kind), 8'(rsp_bus.kind));
               check_field("error_code", 8'(want.err), 8'(rsp_bus.error_code));
               check_field("last_of_run", 8'(want.last), 8'(rsp_bus.last_of_run));
               case (want.kind)
                  jsu_pkg::KIND_BYTE: bytes_checked++;
                  jsu_pkg::KIND_DONE: strings_done++;
                  default: begin
                     errors_checked++;
                     err_codes_seen[want.err] = 1'b1;
                  end
               endcase
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_raw_item('{data: req_bus.data_byte, eot: req_bus.end_of_text});
            requests_taken++;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   // Sets the traffic shape, queues random tokens and waits until all are offered and any hold-off is over.
   task automatic run_random_phase(int idle_pct, int stall_pct, bit with_hold);
      int target;
      @(negedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = counted_items + ITEMS_PER_PHASE;
      while (counted_items < target) queue_token();
      if (with_hold) holds_asked = holds_asked + 1;
      while (raw_bytes_to_send.size() != 0 || hold_left != 0 || holds_started != holds_asked)
         @(negedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = 8'h00;
      req_bus.end_of_text  = 1'b0;
      rsp_bus.ready        = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: whitespace bounds, missing quote on end of text and
      // on a byte, extreme bytes passing through, the slash escape, then one
      // of each error that needs only a short token.
      queue_raw(jsu_pkg::CH_TAB, 1'b0, 1'b0);
      queue_raw(jsu_pkg::CH_CR, 1'b0, 1'b0);
      queue_raw(jsu_pkg::CH_SPACE, 1'b0, 1'b0);
      queue_end();
      queue_byte(8'hFF);
      queue_byte(jsu_pkg::CH_QUOTE);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_text("\\/\"");
      queue_text("\"\\");
      queue_end();
      queue_text("\"\\q");
      queue_text("\"\\uG");
      queue_text("\"\\uDC00");
      queue_byte(jsu_pkg::CH_QUOTE);
      queue_end();

      run_random_phase(0, 0, 1'b0);
      run_random_phase(82, 0, 1'b0);
      run_random_phase(0, 82, 1'b0);
      run_random_phase(30, 30, 1'b0);
      // Receiver holds off while the sender keeps offering, so the block backs up.
      run_random_phase(0, 0, 1'b1);

      // Let everything drain with the receiver always ready.
      rsp_stall_pct = 0;
      while (raw_bytes_to_send.size() != 0 || req_bus.valid) @(negedge clock);
      while (expected_decoded.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d requests: %0d decoded bytes, %0d completed strings, %0d errors.",
               requests_taken, bytes_checked, strings_done, errors_checked);
      $display("Error codes reported (bit per code): %b, with a %0d-cycle output hold-off.",
               err_codes_seen, HOLD_CYCLES);
      if (mismatch_count == 0 && expected_decoded.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_req_if.sv
rtl/core/jsu_rsp_if.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_serial.sv
rtl/core/json_string_unescape_core.sv
rtl/core/jsu_checker.sv
verif/tb_json_string_unescape_core.sv
